// ----- sv/pps_pkg.sv -----
`default_nettype none
package pps_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam logic [5:0] PRIO_LIMIT = 6'd40;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic        vld;
		logic        found;
		logic [5:0]  prio;
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] rem;
	} pps_tok_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [5:0]  prio;
	} pps_load_t;

endpackage
`default_nettype wire

// ----- sv/preemptive_priority_scheduler.sv -----
// An item is accepted, then a scan token walks the row of MAX_PROCESSES cells
// one cell per cycle; the pick at the end of the row is registered, and the result
// is registered once out_valid is clear or out_stall is low.
// No new item is taken from acceptance until the result is registered (in_stall high).
// A new item may be taken while the previous result waits on out_stall.
// Reset (arst_n low): time, done marks and process_count (to 1) are cleared; entries stay undefined.
`default_nettype none
module preemptive_priority_scheduler
	import pps_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [3:0]  slot,
	input  wire logic [7:0]  proc_id,
	input  wire logic [15:0] arrival,
	input  wire logic [15:0] burst,
	input  wire logic [5:0]  priority_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             idle,
	output logic [3:0]       run_slot,
	output logic [7:0]       run_id,
	output logic             finished,
	output logic [31:0]      completion_time,
	output logic [31:0]      turnaround,
	output logic [31:0]      waiting,
	output logic             all_done
);

	localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CW = $clog2(MAX_PROCESSES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_PEND = 2'd2;

	logic [1:0]    state_q;
	logic [4:0]    count_q;
	logic [31:0]   now_q;
	logic          cmd_q;
	logic          start_q;
	pps_tok_t      fin_q;
	logic [IW-1:0] fpick_q;
	logic [CW-1:0] fundone_q;

	logic          out_valid_q;
	logic          idle_q;
	logic [3:0]    run_slot_q;
	logic [7:0]    run_id_q;
	logic          finished_q;
	logic [31:0]   ctime_q;
	logic [31:0]   tat_q;
	logic [31:0]   wt_q;
	logic          all_done_q;

	pps_tok_t      tok    [0:MAX_PROCESSES];
	logic [IW-1:0] pick   [0:MAX_PROCESSES];
	logic [CW-1:0] undone [0:MAX_PROCESSES];

	pps_load_t     ld;
	logic          acc_in;
	logic          go;
	logic          run_en;
	logic          fin_now;
	logic [31:0]   nxt_now;
	logic [31:0]   tat;
	logic [31:0]   wt;
	logic [CW-1:0] undone_after;

	assign acc_in   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign ld.en      = acc_in && (cmd == CMD_LOAD);
	assign ld.slot    = slot;
	assign ld.id      = proc_id;
	assign ld.arrival = arrival;
	assign ld.burst   = burst;
	assign ld.prio    = priority_req;

	assign tok[0]    = '{vld: start_q, found: 1'b0, prio: PRIO_LIMIT, id: 8'd0,
	                     arrival: 16'd0, burst: 16'd0, rem: 16'd0};
	assign pick[0]   = '0;
	assign undone[0] = '0;

	for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
		pps_cell #(
			.MAX_PROCESSES (MAX_PROCESSES),
			.IDX           (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.now_time (now_q),
			.ld       (ld),
			.run_en   (run_en),
			.run_idx  (fpick_q),
			.tok_i    (tok[g]),
			.pick_i   (pick[g]),
			.undone_i (undone[g]),
			.tok_o    (tok[g+1]),
			.pick_o   (pick[g+1]),
			.undone_o (undone[g+1])
		);
	end

	assign go           = (state_q == ST_PEND) && (!out_valid_q || !out_stall);
	assign run_en       = go && (cmd_q == CMD_TICK) && fin_q.found;
	assign fin_now      = run_en && (fin_q.rem == 16'd1);
	assign nxt_now      = (now_q == TIME_MAX) ? now_q : now_q + 32'd1;
	assign tat          = nxt_now - {16'd0, fin_q.arrival};
	assign wt           = (tat >= {16'd0, fin_q.burst}) ? tat - {16'd0, fin_q.burst} : 32'd0;
	assign undone_after = fundone_q - CW'(fin_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			cmd_q   <= CMD_LOAD;
			now_q   <= 32'd0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						cmd_q   <= cmd;
						start_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[MAX_PROCESSES].vld) begin
						state_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					if (go) begin
						if (cmd_q == CMD_TICK) begin
							now_q <= nxt_now;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && tok[MAX_PROCESSES].vld) begin
			fin_q     <= tok[MAX_PROCESSES];
			fpick_q   <= pick[MAX_PROCESSES];
			fundone_q <= undone[MAX_PROCESSES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			idle_q     <= (cmd_q == CMD_TICK) && !fin_q.found;
			run_slot_q <= run_en ? 4'(fpick_q) : 4'd0;
			run_id_q   <= run_en ? fin_q.id : 8'd0;
			finished_q <= fin_now;
			ctime_q    <= fin_now ? nxt_now : 32'd0;
			tat_q      <= fin_now ? tat : 32'd0;
			wt_q       <= fin_now ? wt : 32'd0;
			all_done_q <= (undone_after == '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign idle            = idle_q;
	assign run_slot        = run_slot_q;
	assign run_id          = run_id_q;
	assign finished        = finished_q;
	assign completion_time = ctime_q;
	assign turnaround      = tat_q;
	assign waiting         = wt_q;
	assign all_done        = all_done_q;

endmodule
`default_nettype wire

// ----- sv/pps_cell.sv -----
`default_nettype none
module pps_cell
	import pps_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
	parameter int IDX           = 0,
	localparam int IW           = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
	localparam int CW           = $clog2(MAX_PROCESSES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [4:0]    count,
	input  wire logic [31:0]   now_time,
	input  wire pps_load_t     ld,
	input  wire logic          run_en,
	input  wire logic [IW-1:0] run_idx,
	input  wire pps_tok_t      tok_i,
	input  wire logic [IW-1:0] pick_i,
	input  wire logic [CW-1:0] undone_i,
	output pps_tok_t           tok_o,
	output logic [IW-1:0]      pick_o,
	output logic [CW-1:0]      undone_o
);

	logic [7:0]  id_q;
	logic [15:0] arr_q;
	logic [15:0] burst_q;
	logic [15:0] rem_q;
	logic [5:0]  prio_q;
	logic        done_q;

	pps_tok_t      tok_q;
	logic [IW-1:0] pick_q;
	logic [CW-1:0] undone_q;

	logic sel_ld;
	logic run_hit;
	logic active;
	logic ready;

	assign sel_ld  = ld.en && (int'(ld.slot) == IDX);
	assign run_hit = run_en && (run_idx == IW'(IDX));
	assign active  = (IDX < int'(count));
	assign ready   = active && !done_q && (rem_q != 16'd0) &&
	                 ({16'd0, arr_q} <= now_time) && (prio_q < tok_i.prio);

	always_ff @(posedge clk) begin
		if (sel_ld) begin
			id_q    <= ld.id;
			arr_q   <= ld.arrival;
			burst_q <= ld.burst;
			rem_q   <= ld.burst;
			prio_q  <= ld.prio;
		end else if (run_hit) begin
			rem_q <= rem_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (sel_ld) begin
			done_q <= 1'b0;
		end else if (run_hit && rem_q == 16'd1) begin
			done_q <= 1'b1;
		end
	end

	// scan token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= '0;
			pick_q   <= '0;
			undone_q <= '0;
		end else begin
			tok_q.vld <= tok_i.vld;
			if (tok_i.vld) begin
				undone_q <= undone_i + CW'(active && !done_q);
				if (ready) begin
					tok_q.found   <= 1'b1;
					tok_q.prio    <= prio_q;
					tok_q.id      <= id_q;
					tok_q.arrival <= arr_q;
					tok_q.burst   <= burst_q;
					tok_q.rem     <= rem_q;
					pick_q        <= IW'(IDX);
				end else begin
					tok_q.found   <= tok_i.found;
					tok_q.prio    <= tok_i.prio;
					tok_q.id      <= tok_i.id;
					tok_q.arrival <= tok_i.arrival;
					tok_q.burst   <= tok_i.burst;
					tok_q.rem     <= tok_i.rem;
					pick_q        <= pick_i;
				end
			end
		end
	end

	assign tok_o    = tok_q;
	assign pick_o   = pick_q;
	assign undone_o = undone_q;

endmodule
`default_nettype wire

// ----- sv/pps_chk.sv -----
`default_nettype none
module pps_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        idle,
	input wire logic [3:0]  run_slot,
	input wire logic [7:0]  run_id,
	input wire logic        finished,
	input wire logic [31:0] completion_time,
	input wire logic [31:0] turnaround,
	input wire logic [31:0] waiting
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken during scan");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> !finished && run_slot == 4'd0 && run_id == 8'd0)
		else $error("idle result carries a run");

	a_times_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> turnaround <= completion_time && waiting <= turnaround)
		else $error("finish times out of order");

	a_no_finish_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> completion_time == 32'd0 && turnaround == 32'd0 &&
			waiting == 32'd0)
		else $error("times reported without finish");

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (.*);
`default_nettype wire

// ----- dv/preemptive_priority_scheduler_checker.sv -----
`timescale 1ns / 100ps
module preemptive_priority_scheduler_checker
	import pps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [3:0]  slot,
	input  logic [7:0]  proc_id,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	input  logic [5:0]  priority_req,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        idle,
	input  logic [3:0]  run_slot,
	input  logic [7:0]  run_id,
	input  logic        finished,
	input  logic [31:0] completion_time,
	input  logic [31:0] turnaround,
	input  logic [31:0] waiting,
	input  logic        all_done,
	output int          pending,
	output int          fail_count
);

	localparam int SLOTS = MAX_PROCESSES_DEF;

	typedef struct packed {
		logic        idle;
		logic [3:0]  run_slot;
		logic [7:0]  run_id;
		logic        finished;
		logic [31:0] completion_time;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic        all_done;
	} sched_result_t;

	logic [31:0]   clock_now;
	logic [4:0]    proc_cnt;
	logic [7:0]    tab_id      [SLOTS];
	logic [15:0]   tab_arrival [SLOTS];
	logic [15:0]   tab_burst   [SLOTS];
	logic [15:0]   tab_left    [SLOTS];
	logic [5:0]    tab_prio    [SLOTS];
	logic          tab_done    [SLOTS];
	sched_result_t predicted_q [$];
	int            mismatches = 0;

	function automatic sched_result_t schedule_step(input logic op, input logic [3:0] s,
			input logic [7:0] id, input logic [15:0] arr, input logic [15:0] bst,
			input logic [5:0] prio);
		sched_result_t r;
		int n;
		int i;
		int pick;
		logic [5:0] best;
		logic [31:0] tat;
		r = '0;
		n = (proc_cnt > SLOTS) ? SLOTS : int'(proc_cnt);
		if (op == CMD_LOAD) begin
			tab_id[s] = id;
			tab_arrival[s] = arr;
			tab_burst[s] = bst;
			tab_left[s] = bst;
			tab_prio[s] = prio;
			tab_done[s] = 1'b0;
		end else begin
			best = PRIO_LIMIT;
			pick = -1;
			for (i = 0; i < n; i++) begin
				if ({16'd0, tab_arrival[i]} <= clock_now && !tab_done[i] &&
						tab_left[i] != 16'd0 && tab_prio[i] < best) begin
					best = tab_prio[i];
					pick = i;
				end
			end
			if (clock_now != TIME_MAX)
				clock_now = clock_now + 32'd1;
			if (pick < 0) begin
				r.idle = 1'b1;
			end else begin
				r.run_slot = pick[3:0];
				r.run_id = tab_id[pick];
				tab_left[pick] = tab_left[pick] - 16'd1;
				if (tab_left[pick] == 16'd0) begin
					tat = clock_now - {16'd0, tab_arrival[pick]};
					tab_done[pick] = 1'b1;
					r.finished = 1'b1;
					r.completion_time = clock_now;
					r.turnaround = tat;
					r.waiting = (tat >= {16'd0, tab_burst[pick]}) ?
						tat - {16'd0, tab_burst[pick]} : 32'd0;
				end
			end
		end
		r.all_done = 1'b1;
		for (i = 0; i < n; i++)
			if (!tab_done[i])
				r.all_done = 1'b0;
		return r;
	endfunction

	function automatic void check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, fname, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : watch
		sched_result_t want;
		int i;
		if (!arst_n) begin
			clock_now = '0;
			proc_cnt = 5'd1;
			for (i = 0; i < SLOTS; i++)
				tab_done[i] = 1'b0;
			predicted_q.delete();
		end else begin
			if (cfg_we)
				proc_cnt = cfg_data;
			if (out_valid && !out_stall) begin
				if (predicted_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result item with nothing expected", $realtime);
					mismatches++;
				end else begin
					want = predicted_q.pop_front();
					check_field("idle", 32'(want.idle), 32'(idle));
					check_field("run_slot", 32'(want.run_slot), 32'(run_slot));
					check_field("run_id", 32'(want.run_id), 32'(run_id));
					check_field("finished", 32'(want.finished), 32'(finished));
					check_field("completion_time", want.completion_time, completion_time);
					check_field("turnaround", want.turnaround, turnaround);
					check_field("waiting", want.waiting, waiting);
					check_field("all_done", 32'(want.all_done), 32'(all_done));
				end
			end
			if (in_valid && !in_stall)
				predicted_q.push_back(schedule_step(cmd, slot, proc_id, arrival, burst,
					priority_req));
		end
		pending <= predicted_q.size();
		fail_count <= mismatches;
	end

endmodule

// ----- dv/preemptive_priority_scheduler_tb.sv -----
`timescale 1ns / 100ps
module preemptive_priority_scheduler_tb;
	import pps_pkg::*;

	localparam int ITEM_GOAL   = 1650;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SLOTS       = MAX_PROCESSES_DEF;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [3:0]  slot;
	logic [7:0]  proc_id;
	logic [15:0] arrival;
	logic [15:0] burst;
	logic [5:0]  priority_req;
	logic        out_valid;
	logic        out_stall;
	logic        idle;
	logic [3:0]  run_slot;
	logic [7:0]  run_id;
	logic        finished;
	logic [31:0] completion_time;
	logic [31:0] turnaround;
	logic [31:0] waiting;
	logic        all_done;
	int          pending;
	int          fail_count;

	int cycle_cnt    = 0;
	int items_sent   = 0;
	int ticks_sent   = 0;
	int active_slots = 1;
	bit tx_quiet     = 1'b0;
	bit slot_loaded [SLOTS];

	preemptive_priority_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .slot(slot),
		.proc_id(proc_id), .arrival(arrival), .burst(burst), .priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall), .idle(idle), .run_slot(run_slot),
		.run_id(run_id), .finished(finished), .completion_time(completion_time),
		.turnaround(turnaround), .waiting(waiting), .all_done(all_done)
	);

	preemptive_priority_scheduler_checker u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .slot(slot),
		.proc_id(proc_id), .arrival(arrival), .burst(burst), .priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall), .idle(idle), .run_slot(run_slot),
		.run_id(run_id), .finished(finished), .completion_time(completion_time),
		.turnaround(turnaround), .waiting(waiting), .all_done(all_done),
		.pending(pending), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off once traffic is flowing
	initial begin : rx_side
		int len;
		int r;
		int seen;
		bit held;
		seen = 0;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && seen >= 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				len = 700;
			end else if (r < 30) begin
				out_stall <= 1'b1;
				len = (r < 3) ? $urandom_range(20, 60) : $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b0;
				len = (r > 94) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			end
			repeat (len) begin
				@(posedge clk);
				if (out_valid && !out_stall)
					seen++;
			end
		end
	end

	function automatic int tx_gap();
		int r;
		if (tx_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic c, input logic [3:0] s, input logic [7:0] id,
			input logic [15:0] a, input logic [15:0] b, input logic [5:0] p);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		slot <= s;
		proc_id <= id;
		arrival <= a;
		burst <= b;
		priority_req <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (c == CMD_TICK)
			ticks_sent++;
		else
			slot_loaded[s] = 1'b1;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_count(input logic [4:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_slots = (v > SLOTS) ? SLOTS : int'(v);
	endtask

	// mostly near-term arrivals and short bursts so entries actually run
	task automatic load_slot(input logic [3:0] s);
		int r;
		int a;
		int b;
		int p;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			a = ticks_sent + $urandom_range(0, 12);
		end else if (r < 85) begin
			a = $urandom_range(0, 20);
			a = ticks_sent - a;
			if (a < 0)
				a = 0;
		end else if (r < 95) begin
			a = $urandom_range(0, 65535);
		end else begin
			a = 0;
		end
		r = $urandom_range(0, 99);
		if (r < 80)
			b = $urandom_range(1, 6);
		else if (r < 92)
			b = $urandom_range(7, 30);
		else if (r < 96)
			b = 0;
		else
			b = $urandom_range(0, 65535);
		r = $urandom_range(0, 99);
		if (r < 45)
			p = $urandom_range(0, 7);
		else if (r < 90)
			p = $urandom_range(0, 39);
		else
			p = $urandom_range(40, 63);
		send_item(CMD_LOAD, s, 8'($urandom_range(0, 255)), a[15:0], b[15:0], p[5:0]);
	endtask

	function automatic int pick_slot();
		if (active_slots > 0 && $urandom_range(0, 99) < 90)
			return $urandom_range(0, active_slots - 1);
		return $urandom_range(0, SLOTS - 1);
	endfunction

	// every slot taking part must hold an entry before a tick
	task automatic tick();
		int i;
		for (i = 0; i < active_slots; i++)
			if (!slot_loaded[i])
				load_slot(i[3:0]);
		send_item(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			6'($urandom_range(0, 63)));
	endtask

	task automatic noise_item();
		if ($urandom_range(0, 1))
			tick();
		else
			send_item(CMD_LOAD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				6'($urandom_range(0, 63)));
	endtask

	initial begin : stimulus
		int count_plan [10];
		int phase;
		int r;
		int cnt;
		count_plan = '{16, 1, 31, 0, 5, 17, 2, 16, 9, 12};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		slot = '0;
		proc_id = '0;
		arrival = '0;
		burst = '0;
		priority_req = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// no slot taking part: idle tick, all done; load outside the count
		set_count(5'd0);
		tick();
		send_item(CMD_LOAD, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F);

		// zero burst never runs; slot 2 arrives later and preempts slot 1
		set_count(5'd3);
		send_item(CMD_LOAD, 4'd0, 8'h00, 16'h0000, 16'h0000, 6'd0);
		send_item(CMD_LOAD, 4'd1, 8'hAA, 16'd0, 16'd3, 6'd39);
		send_item(CMD_LOAD, 4'd2, 8'h55, 16'd2, 16'd1, 6'd5);
		repeat (5) tick();

		// reload of a finished slot at the priority limit
		send_item(CMD_LOAD, 4'd1, 8'h11, 16'd0, 16'd4, PRIO_LIMIT);
		tick();

		// equal priorities: lowest slot first, then everything done
		send_item(CMD_LOAD, 4'd0, 8'h21, 16'd0, 16'd2, 6'd7);
		send_item(CMD_LOAD, 4'd1, 8'h22, 16'd0, 16'd1, 6'd7);
		repeat (3) tick();
		send_item(CMD_LOAD, 4'd2, 8'h33, 16'd9, 16'd2, 6'd0);
		tick();

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			if (phase < 10) begin
				cnt = count_plan[phase];
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50)
					cnt = 16;
				else if (r < 75)
					cnt = $urandom_range(1, 15);
				else
					cnt = $urandom_range(0, 31);
			end
			set_count(cnt[4:0]);
			tx_quiet = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 6)) begin
				repeat ($urandom_range(1, 6))
					load_slot(4'(pick_slot()));
				repeat ($urandom_range(5, 40)) begin
					r = $urandom_range(0, 99);
					if (r < 8)
						load_slot(4'(pick_slot()));
					else if (r < 12)
						noise_item();
					else
						tick();
				end
			end
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler.sv
sv/pps_chk.sv
dv/preemptive_priority_scheduler_checker.sv
dv/preemptive_priority_scheduler_tb.sv
